@@ design/lcdseq_pkg.sv @@
// Package for the character LCD command sequencer.
// Holds transfer and command types, LCD instruction codes and the small decode tables.
// No dependencies; every other design file imports it.
package lcdseq_pkg;

  // Display geometry and cursor limits
  localparam int unsigned LINE_WIDTH_DEF = 16;
  localparam logic [5:0]  CURSOR_MAX     = 6'd63;
  localparam logic [4:0]  BAR_MAX_CELLS  = 5'd16;

  // Host command codes
  localparam logic [3:0] FN_INIT       = 4'd0;
  localparam logic [3:0] FN_CGRAM      = 4'd1;
  localparam logic [3:0] FN_GLYPH      = 4'd2;
  localparam logic [3:0] FN_CLEAR      = 4'd3;
  localparam logic [3:0] FN_GOTO       = 4'd4;
  localparam logic [3:0] FN_PUTC       = 4'd5;
  localparam logic [3:0] FN_CURSOR_OFF = 4'd6;
  localparam logic [3:0] FN_DISPLAY_ON = 4'd7;
  localparam logic [3:0] FN_BARGRAPH   = 4'd8;

  // LCD instruction bytes and init nibbles
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_CURS  = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_CURSOR_OFF = 8'h0C;
  localparam logic [7:0] CMD_LINE2_HOME = 8'hC0;
  localparam logic [7:0] CMD_CGRAM_ADDR = 8'h40;
  localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] LINE2_OFFSET   = 8'h40;
  localparam logic [7:0] NIB_WAKE       = 8'h03;
  localparam logic [7:0] NIB_4BIT       = 8'h02;

  // Bargraph scaling: one glyph level per BAR_UNIT of percent*cells
  localparam int unsigned PROD_W        = 11;
  localparam logic [10:0] BAR_UNIT      = 11'd20;
  localparam logic [10:0] BAR_FULL_MIN  = BAR_UNIT * 11'd6;
  localparam logic [10:0] BAR_FULL_STEP = BAR_UNIT * 11'd5;
  localparam logic [2:0]  BAR_FULL_GLYPH = 3'd5;

  // Init script length
  localparam logic [3:0] INIT_LAST_STEP = 4'd8;

  // Transfer kinds
  localparam logic KIND_NIBBLE = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;
  localparam logic RS_INSTR    = 1'b0;
  localparam logic RS_DATA     = 1'b1;

  // Input item
  typedef struct packed {
    logic [3:0] func;
    logic [7:0] char_code;
    logic [4:0] column;
    logic [1:0] row;
    logic [6:0] bar_percent;
    logic [4:0] bar_cells;
  } in_item_t;

  // Result item, one per LCD transfer
  typedef struct packed {
    logic       transfer_kind;
    logic       reg_select;
    logic [7:0] value;
    logic       last_transfer;
  } out_item_t;

  // Classified job handed from front to back
  typedef enum logic [2:0] {
    OP_INIT,
    OP_CLEAR,
    OP_SINGLE,
    OP_GOTO,
    OP_PUTC,
    OP_BAR
  } job_op_t;

  typedef struct packed {
    job_op_t           op;
    logic              rs;
    logic [7:0]        value;
    logic [5:0]        target;
    logic [PROD_W-1:0] prod;
    logic [4:0]        cells;
  } job_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_BUSY
  } bk_state_t;

  // One transfer of the power-on script
  function automatic out_item_t init_xfer(input logic [3:0] step);
    out_item_t x;
    x.transfer_kind = KIND_BYTE;
    x.reg_select    = RS_INSTR;
    x.last_transfer = 1'b0;
    case (step) inside
      4'd0, 4'd1, 4'd2: begin
        x.transfer_kind = KIND_NIBBLE;
        x.value         = NIB_WAKE;
      end
      4'd3: begin
        x.transfer_kind = KIND_NIBBLE;
        x.value         = NIB_4BIT;
      end
      4'd4: x.value = CMD_FUNC_SET;
      4'd5: x.value = CMD_DISP_CURS;
      4'd6: x.value = CMD_ENTRY_MODE;
      4'd7: x.value = CMD_CLEAR;
      default: begin
        x.value         = CMD_DDRAM_ADDR;
        x.last_transfer = 1'b1;
      end
    endcase
    return x;
  endfunction

  // Glyph for a remainder below the full threshold (r / BAR_UNIT, capped at 5)
  function automatic logic [2:0] bar_glyph(input logic [PROD_W-1:0] r);
    logic [2:0] g;
    if (r >= BAR_UNIT * 11'd5)      g = 3'd5;
    else if (r >= BAR_UNIT * 11'd4) g = 3'd4;
    else if (r >= BAR_UNIT * 11'd3) g = 3'd3;
    else if (r >= BAR_UNIT * 11'd2) g = 3'd2;
    else if (r >= BAR_UNIT)         g = 3'd1;
    else                            g = 3'd0;
    return g;
  endfunction

endpackage

@@ design/lcdseq_front.sv @@
// Front end: accepts host commands and classifies them into jobs.
// Works out goto address and cursor target, and the bargraph product.
// Depends on lcdseq_pkg.
module lcdseq_front import lcdseq_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job_data
);

  localparam logic [5:0] LW6 = 6'(LINE_WIDTH);

  logic     fv_r, fv_nxt;
  job_t     fjob_r;
  job_t     cls;
  logic     keep;
  logic     accept;
  logic [5:0] col6, col_c, x;
  logic       line;
  logic [6:0] target7;
  logic [4:0] cells_c;

  assign in_stall  = fv_r & ~job_ready;
  assign accept    = in_valid & ~in_stall;
  assign job_valid = fv_r;
  assign job_data  = fjob_r;

  // Goto address: clamp column, pick line, saturate cursor target
  always_comb begin
    col6 = {1'b0, in_data.column};
    if (col6 == 6'd0)     col_c = 6'd1;
    else if (col6 > LW6)  col_c = LW6;
    else                  col_c = col6;
    x       = col_c - 6'd1;
    line    = (in_data.row != 2'd1);
    target7 = (line ? {1'b0, LW6} : 7'd0) + {1'b0, x};
    cells_c = (in_data.bar_cells > BAR_MAX_CELLS) ? BAR_MAX_CELLS : in_data.bar_cells;
  end

  // Command decode
  always_comb begin
    keep       = 1'b1;
    cls.op     = OP_SINGLE;
    cls.rs     = RS_INSTR;
    cls.value  = in_data.char_code;
    cls.target = (target7 > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : target7[5:0];
    cls.prod   = {4'b0, in_data.bar_percent} * {6'b0, cells_c};
    cls.cells  = cells_c;
    unique case (in_data.func)
      FN_INIT:       cls.op = OP_INIT;
      FN_CGRAM:      cls.value = CMD_CGRAM_ADDR;
      FN_GLYPH:      cls.rs = RS_DATA;
      FN_CLEAR:      cls.op = OP_CLEAR;
      FN_GOTO: begin
        cls.op    = OP_GOTO;
        cls.value = CMD_DDRAM_ADDR | (line ? LINE2_OFFSET : 8'h00) | {2'b0, x};
      end
      FN_PUTC:       cls.op = OP_PUTC;
      FN_CURSOR_OFF: cls.value = CMD_CURSOR_OFF;
      FN_DISPLAY_ON: cls.value = CMD_DISP_CURS;
      FN_BARGRAPH: begin
        cls.op = OP_BAR;
        keep   = (cells_c != 5'd0);
      end
      default:       keep = 1'b0;
    endcase
  end

  // Holding register; a dropped command simply never becomes valid
  always_comb begin
    fv_nxt = fv_r;
    if (accept)         fv_nxt = keep;
    else if (job_ready) fv_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fjob_r <= cls;
    end
  end

endmodule

@@ design/lcdseq_queue.sv @@
// Two-entry job queue between the front and back ends.
// Depends on lcdseq_pkg for the job type.
module lcdseq_queue import lcdseq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_data
);

  job_t       mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ design/lcdseq_back.sv @@
// Back end: expands one job into LCD transfers, one per cycle while not stalled, and owns the cursor.
// Drives the registered result channel. Depends on lcdseq_pkg.
module lcdseq_back import lcdseq_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  job_t      q_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [5:0] LW6 = 6'(LINE_WIDTH);

  bk_state_t         state_r, state_nxt;
  job_t              job_r;
  logic [3:0]        step_r, step_nxt;
  logic [5:0]        cursor_r, cursor_nxt;
  logic              wrap_r, wrap_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [4:0]        cells_r, cells_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              can_emit, emit, full;
  logic [2:0]        glyph;
  logic [7:0]        char_byte;
  out_item_t         xfer;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_emit  = ~out_valid_r | ~out_stall;
  assign full      = (rem_r >= BAR_FULL_MIN);
  assign glyph     = full ? BAR_FULL_GLYPH : bar_glyph(rem_r);
  assign char_byte = (job_r.op == OP_BAR) ? {5'b0, glyph} : job_r.value;

  // Sequencer: next state and the transfer for this cycle
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cursor_nxt = cursor_r;
    wrap_nxt   = wrap_r;
    rem_nxt    = rem_r;
    cells_nxt  = cells_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    xfer       = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          step_nxt  = 4'd0;
          wrap_nxt  = 1'b0;
          rem_nxt   = q_data.prod;
          cells_nxt = q_data.cells;
          state_nxt = BK_BUSY;
        end
      end
      BK_BUSY: begin
        if (can_emit) begin
          emit = 1'b1;
          xfer.transfer_kind = KIND_BYTE;
          xfer.reg_select    = RS_INSTR;
          case (job_r.op) inside
            OP_INIT: begin
              xfer     = init_xfer(step_r);
              step_nxt = step_r + 4'd1;
              if (step_r == INIT_LAST_STEP) cursor_nxt = 6'd0;
            end
            OP_CLEAR: begin
              step_nxt = step_r + 4'd1;
              if (step_r == 4'd0) begin
                xfer.value = CMD_CLEAR;
              end else begin
                xfer.value         = CMD_DDRAM_ADDR;
                xfer.last_transfer = 1'b1;
                cursor_nxt         = 6'd0;
              end
            end
            OP_SINGLE: begin
              xfer.reg_select    = job_r.rs;
              xfer.value         = job_r.value;
              xfer.last_transfer = 1'b1;
            end
            OP_GOTO: begin
              xfer.value         = job_r.value;
              xfer.last_transfer = 1'b1;
              cursor_nxt         = job_r.target;
            end
            OP_PUTC, OP_BAR: begin
              if (cursor_r == LW6 && !wrap_r) begin
                // end of line one: move to line two before the character
                xfer.value = CMD_LINE2_HOME;
                wrap_nxt   = 1'b1;
              end else begin
                xfer.reg_select = RS_DATA;
                xfer.value      = char_byte;
                wrap_nxt        = 1'b0;
                cursor_nxt      = (cursor_r == CURSOR_MAX) ? CURSOR_MAX : cursor_r + 6'd1;
                if (job_r.op == OP_PUTC) begin
                  xfer.last_transfer = 1'b1;
                end else begin
                  xfer.last_transfer = ~full | (cells_r == 5'd1);
                  cells_nxt          = cells_r - 5'd1;
                  if (full) rem_nxt = rem_r - BAR_FULL_STEP;
                end
              end
            end
            default: begin
              emit      = 1'b0;
              state_nxt = BK_IDLE;
            end
          endcase
          if (emit && xfer.last_transfer) state_nxt = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cursor_r    <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      if (can_emit) out_valid_r <= emit;
    end
  end

  // Job context and output payload
  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    wrap_r  <= wrap_nxt;
    rem_r   <= rem_nxt;
    cells_r <= cells_nxt;
    if (q_pop) job_r <= q_data;
    if (can_emit && emit) out_data_r <= xfer;
  end

endmodule

@@ design/char_lcd_command_sequencer_top.sv @@
// Top level of the character LCD command sequencer (4-bit HD44780-style bus).
// Instantiates lcdseq_front, lcdseq_queue and lcdseq_back; depends on lcdseq_pkg.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-----------------------------
//   input   | in_valid / in_stall / in_data  | in_item_t, one host command
//   result  | out_valid / out_stall / out_data | out_item_t, one LCD transfer
//
// Each command passes through the front register and the queue, and the back sequencer
// loads it from the queue before its first transfer appears on the registered result
// channel. The back end then emits one transfer per cycle while the result channel is
// not stalled, and returns to idle after each command's last transfer to load the next.
// Unknown commands and empty bargraphs are dropped in the front with no result.
// Reset clears the cursor to 0 and empties the queue; both sides stall freely.
module char_lcd_command_sequencer_top import lcdseq_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF  // 8..40
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic fq_valid, fq_ready;
  job_t fq_data;
  logic qb_valid, qb_pop;
  job_t qb_data;

  lcdseq_front #(.LINE_WIDTH(LINE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  lcdseq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .pop_data   (qb_data)
  );

  lcdseq_back #(.LINE_WIDTH(LINE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_pop     (qb_pop),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/lcdseq_checker.sv @@
// Port-level checks for the character LCD command sequencer.
// Bound to char_lcd_command_sequencer_top; depends on lcdseq_pkg.
module lcdseq_checker import lcdseq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled command transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("command changed while stalled");

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Lone nibbles only go to the instruction register and fit in four bits
  a_nibble_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transfer_kind == KIND_NIBBLE |->
      out_data.reg_select == RS_INSTR && out_data.value[7:4] == 4'h0)
    else $error("malformed nibble transfer");

  // The init nibbles are always followed by byte transfers
  a_nibble_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transfer_kind == KIND_NIBBLE |-> !out_data.last_transfer)
    else $error("command ended on a nibble");

endmodule

bind char_lcd_command_sequencer_top lcdseq_checker u_lcdseq_checker (.*);

@@ dv/char_lcd_command_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for char_lcd_command_sequencer_top: host commands in, LCD transfers out.
// Depends on lcdseq_pkg and the design top; needs no files, arguments or external code.

module char_lcd_command_sequencer_top_tb;
  import lcdseq_pkg::*;

  localparam int LINE_W = LINE_WIDTH_DEF;
  localparam logic [3:0] FN_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] FN_UNKNOWN_HI = 4'd15;
  localparam int RAND_PER_PHASE = 115;
  localparam int HOLD_ITEMS     = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  // One command of stimulus; fixed rows carry their transfer typed in by hand
  typedef struct packed {
    in_item_t  cmd;
    logic      fixed;
    logic      has_xfer;
    out_item_t xfer;
  } cmd_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Idle/stall mixes of the random phases (sender idle %, receiver stall %)
  int idle_mix[4]  = '{0, 76, 0, 9};
  int stall_mix[4] = '{0, 0, 76, 9};

  logic [5:0] cursor_pos;       // predicted cursor index
  out_item_t  lcd_xfers[$];     // transfers of the command being predicted
  out_item_t  xfer_due_q[$];    // expected transfers, oldest first
  cmd_row_t   offered_q[$];     // commands offered, in order

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors        = 0;
  int cmds_sent     = 0;
  int xfers_checked = 0;
  int quiet_cycles  = 0;

  char_lcd_command_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void push_xfer(logic kind, logic rs, logic [7:0] val);
    out_item_t x;
    x.transfer_kind = kind;
    x.reg_select    = rs;
    x.value         = val;
    x.last_transfer = 1'b0;
    lcd_xfers.push_back(x);
  endfunction

  function automatic void bump_cursor(int nxt);
    cursor_pos = (nxt > int'(CURSOR_MAX)) ? CURSOR_MAX : nxt[5:0];
  endfunction

  // Printing at the end of line one jumps to line two first
  function automatic void print_char(logic [7:0] ch);
    if (int'(cursor_pos) == LINE_W) push_xfer(KIND_BYTE, RS_INSTR, CMD_LINE2_HOME);
    push_xfer(KIND_BYTE, RS_DATA, ch);
    bump_cursor(int'(cursor_pos) + 1);
  endfunction

  // Column clamped into the line, any row but 1 means line two
  function automatic void move_cursor(logic [4:0] col, logic [1:0] row);
    int   x;
    logic line2;
    if (col < 5'd1) x = 0;
    else if (int'(col) > LINE_W) x = LINE_W - 1;
    else x = int'(col) - 1;
    line2 = (row != 2'd1);
    push_xfer(KIND_BYTE, RS_INSTR,
              CMD_DDRAM_ADDR | (line2 ? LINE2_OFFSET : 8'h00) | 8'(x));
    bump_cursor((line2 ? LINE_W : 0) + x);
  endfunction

  function automatic void predict_xfers(in_item_t c);
    int        cells;
    int        lvl;
    bit        done;
    out_item_t tail;
    lcd_xfers.delete();
    case (c.func)
      FN_INIT: begin
        push_xfer(KIND_NIBBLE, RS_INSTR, NIB_WAKE);
        push_xfer(KIND_NIBBLE, RS_INSTR, NIB_WAKE);
        push_xfer(KIND_NIBBLE, RS_INSTR, NIB_WAKE);
        push_xfer(KIND_NIBBLE, RS_INSTR, NIB_4BIT);
        push_xfer(KIND_BYTE, RS_INSTR, CMD_FUNC_SET);
        push_xfer(KIND_BYTE, RS_INSTR, CMD_DISP_CURS);
        push_xfer(KIND_BYTE, RS_INSTR, CMD_ENTRY_MODE);
        push_xfer(KIND_BYTE, RS_INSTR, CMD_CLEAR);
        move_cursor(5'd1, 2'd1);
      end
      FN_CGRAM:      push_xfer(KIND_BYTE, RS_INSTR, CMD_CGRAM_ADDR);
      FN_GLYPH:      push_xfer(KIND_BYTE, RS_DATA, c.char_code);
      FN_CLEAR: begin
        push_xfer(KIND_BYTE, RS_INSTR, CMD_CLEAR);
        move_cursor(5'd1, 2'd1);
      end
      FN_GOTO:       move_cursor(c.column, c.row);
      FN_PUTC:       print_char(c.char_code);
      FN_CURSOR_OFF: push_xfer(KIND_BYTE, RS_INSTR, CMD_CURSOR_OFF);
      FN_DISPLAY_ON: push_xfer(KIND_BYTE, RS_INSTR, CMD_DISP_CURS);
      FN_BARGRAPH: begin
        // full glyphs while the level exceeds one cell, then the remainder glyph
        cells = (c.bar_cells > BAR_MAX_CELLS) ? int'(BAR_MAX_CELLS) : int'(c.bar_cells);
        lvl   = int'(c.bar_percent) * cells / int'(BAR_UNIT);
        done  = 1'b0;
        for (int i = 0; i < cells && !done; i++) begin
          if (lvl > int'(BAR_FULL_GLYPH)) begin
            print_char(8'(BAR_FULL_GLYPH));
            lvl = lvl - int'(BAR_FULL_GLYPH);
          end else begin
            print_char(8'(lvl));
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (lcd_xfers.size() > 0) begin
      tail = lcd_xfers[lcd_xfers.size() - 1];
      tail.last_transfer = 1'b1;
      lcd_xfers[lcd_xfers.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic in_item_t mk_cmd(logic [3:0] fn, logic [7:0] code, logic [4:0] col,
                                      logic [1:0] row, logic [6:0] pct, logic [4:0] cells);
    in_item_t c;
    c.func        = fn;
    c.char_code   = code;
    c.column      = col;
    c.row         = row;
    c.bar_percent = pct;
    c.bar_cells   = cells;
    return c;
  endfunction

  function automatic cmd_row_t predicted(in_item_t c);
    cmd_row_t r;
    r.cmd      = c;
    r.fixed    = 1'b0;
    r.has_xfer = 1'b0;
    r.xfer     = '0;
    return r;
  endfunction

  function automatic cmd_row_t typed(in_item_t c, logic has, logic rs, logic [7:0] val);
    cmd_row_t r;
    r.cmd                = c;
    r.fixed              = 1'b1;
    r.has_xfer           = has;
    r.xfer.transfer_kind = KIND_BYTE;
    r.xfer.reg_select    = rs;
    r.xfer.value         = val;
    r.xfer.last_transfer = 1'b1;
    return r;
  endfunction

  // Mostly printing and cursor moves so the line wrap and saturation get hit
  function automatic in_item_t rand_cmd();
    logic [31:0] bits;
    in_item_t    c;
    int          pick;
    bits = $urandom;
    c    = bits[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 40)      c.func = FN_PUTC;
    else if (pick < 50) c.func = FN_GOTO;
    else if (pick < 65) c.func = FN_BARGRAPH;
    else if (pick < 70) c.func = FN_GLYPH;
    else if (pick < 74) c.func = FN_CGRAM;
    else if (pick < 78) c.func = FN_CLEAR;
    else if (pick < 80) c.func = FN_INIT;
    else if (pick < 84) c.func = FN_CURSOR_OFF;
    else if (pick < 88) c.func = FN_DISPLAY_ON;
    else if (pick < 92) c.func = 4'($urandom_range(FN_UNKNOWN_HI, FN_UNKNOWN_LO));
    // most bargraphs in range so the level walk runs over several cells
    if (c.func == FN_BARGRAPH && $urandom_range(3) != 0) begin
      c.bar_cells   = 5'($urandom_range(16, 1));
      c.bar_percent = 7'($urandom_range(100));
    end
    return c;
  endfunction

  // Offer one command and hold it until the transfer happens
  task automatic send_cmd(cmd_row_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= rand_cmd();
      @(posedge clk);
    end
    offered_q.push_back(row);
    in_valid <= 1'b1;
    in_data  <= row.cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmds_sent++;
  endtask

  // Stop offering until every expected transfer has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (xfer_due_q.size() != 0 || offered_q.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  // ---------------------------------------------------------------- monitors
  // Accepted command: predict its transfers
  always @(posedge clk) begin : cmd_monitor
    cmd_row_t row;
    if (rst_n && in_valid && !in_stall && offered_q.size() != 0) begin
      row = offered_q.pop_front();
      predict_xfers(row.cmd);
      if (row.fixed) begin
        if (row.has_xfer) xfer_due_q.push_back(row.xfer);
      end else begin
        foreach (lcd_xfers[i]) xfer_due_q.push_back(lcd_xfers[i]);
      end
    end
  end

  // Accepted transfer: compare with the oldest expectation
  always @(posedge clk) begin : xfer_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      xfers_checked++;
      if (xfer_due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: expected none, actual kind=%0d rs=%0d value=%0h last=%0d",
                 $time, out_data.transfer_kind, out_data.reg_select, out_data.value,
                 out_data.last_transfer);
      end else begin
        want = xfer_due_q.pop_front();
        check_field("transfer_kind", 8'(want.transfer_kind), 8'(out_data.transfer_kind));
        check_field("reg_select", 8'(want.reg_select), 8'(out_data.reg_select));
        check_field("value", want.value, out_data.value);
        check_field("last_transfer", 8'(want.last_transfer), 8'(out_data.last_transfer));
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_seen + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: too long with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin : stim_main
    cmd_row_t dir_tbl[$];

    // directed table: extremes, every command, the special cases
    dir_tbl.push_back(predicted(mk_cmd(FN_INIT, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0)));
    dir_tbl.push_back(predicted(mk_cmd(FN_PUTC, 8'h41, 5'd0, 2'd0, 7'd0, 5'd0)));
    dir_tbl.push_back(typed(mk_cmd(FN_GLYPH, 8'hFF, 5'd0, 2'd0, 7'd0, 5'd0), 1'b1, RS_DATA,
                            8'hFF));
    dir_tbl.push_back(typed(mk_cmd(FN_GLYPH, 8'h00, 5'h1F, 2'd3, 7'h7F, 5'h1F), 1'b1, RS_DATA,
                            8'h00));
    dir_tbl.push_back(typed(mk_cmd(FN_CGRAM, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0), 1'b1, RS_INSTR,
                            CMD_CGRAM_ADDR));
    dir_tbl.push_back(typed(mk_cmd(FN_CURSOR_OFF, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0), 1'b1,
                            RS_INSTR, CMD_CURSOR_OFF));
    dir_tbl.push_back(typed(mk_cmd(FN_DISPLAY_ON, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0), 1'b1,
                            RS_INSTR, CMD_DISP_CURS));
    dir_tbl.push_back(typed(mk_cmd(FN_GOTO, 8'h00, 5'd1, 2'd1, 7'd0, 5'd0), 1'b1, RS_INSTR,
                            CMD_DDRAM_ADDR));
    dir_tbl.push_back(typed(mk_cmd(FN_GOTO, 8'h00, 5'd16, 2'd2, 7'd0, 5'd0), 1'b1, RS_INSTR,
                            CMD_DDRAM_ADDR | LINE2_OFFSET | 8'd15));
    // column below range, row zero
    dir_tbl.push_back(typed(mk_cmd(FN_GOTO, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0), 1'b1, RS_INSTR,
                            CMD_DDRAM_ADDR | LINE2_OFFSET));
    // column above range, row three
    dir_tbl.push_back(typed(mk_cmd(FN_GOTO, 8'hFF, 5'h1F, 2'd3, 7'd0, 5'd0), 1'b1, RS_INSTR,
                            CMD_DDRAM_ADDR | LINE2_OFFSET | 8'd15));
    dir_tbl.push_back(typed(mk_cmd(FN_GOTO, 8'h00, 5'd16, 2'd1, 7'd0, 5'd0), 1'b1, RS_INSTR,
                            CMD_DDRAM_ADDR | 8'd15));
    // last column of line one, then the wrap to line two
    dir_tbl.push_back(predicted(mk_cmd(FN_PUTC, 8'h7E, 5'd0, 2'd0, 7'd0, 5'd0)));
    dir_tbl.push_back(predicted(mk_cmd(FN_PUTC, 8'h20, 5'd0, 2'd0, 7'd0, 5'd0)));
    // unknown commands and the empty bargraph give nothing
    dir_tbl.push_back(typed(mk_cmd(FN_UNKNOWN_LO, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0), 1'b0,
                            RS_INSTR, 8'h00));
    dir_tbl.push_back(typed(mk_cmd(FN_UNKNOWN_HI, 8'hFF, 5'h1F, 2'd3, 7'h7F, 5'h1F), 1'b0,
                            RS_INSTR, 8'h00));
    dir_tbl.push_back(typed(mk_cmd(FN_BARGRAPH, 8'h00, 5'd0, 2'd0, 7'd100, 5'd0), 1'b0,
                            RS_INSTR, 8'h00));
    // full bars, oversize cells and percent, cursor saturation
    dir_tbl.push_back(predicted(mk_cmd(FN_BARGRAPH, 8'h00, 5'd0, 2'd0, 7'd100, 5'd16)));
    dir_tbl.push_back(predicted(mk_cmd(FN_BARGRAPH, 8'h00, 5'd0, 2'd0, 7'h7F, 5'h1F)));
    dir_tbl.push_back(predicted(mk_cmd(FN_BARGRAPH, 8'h00, 5'd0, 2'd0, 7'h7F, 5'h1F)));
    dir_tbl.push_back(predicted(mk_cmd(FN_BARGRAPH, 8'h00, 5'd0, 2'd0, 7'd0, 5'd1)));
    dir_tbl.push_back(predicted(mk_cmd(FN_CLEAR, 8'h00, 5'd0, 2'd0, 7'd0, 5'd0)));
    // bargraph that crosses the end of line one
    dir_tbl.push_back(predicted(mk_cmd(FN_GOTO, 8'h00, 5'd16, 2'd1, 7'd0, 5'd0)));
    dir_tbl.push_back(predicted(mk_cmd(FN_BARGRAPH, 8'h00, 5'd0, 2'd0, 7'd100, 5'd4)));
    dir_tbl.push_back(predicted(mk_cmd(FN_PUTC, 8'hFF, 5'd0, 2'd0, 7'd0, 5'd0)));

    // synchronous reset, predictor starts from the reset cursor
    cursor_pos = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) send_cmd(dir_tbl[i]);
    drain();

    // random phases, each ends with the sender paused until all results are in
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      repeat (RAND_PER_PHASE) send_cmd(predicted(rand_cmd()));
      drain();
    end

    // long receiver hold-off with the sender pushing, so the block backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_asks = hold_asks + 1;
    repeat (HOLD_ITEMS) send_cmd(predicted(rand_cmd()));
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d commands (%0d directed, the rest random) over four idle/stall mixes",
             cmds_sent, dir_tbl.size());
    $display("and a long receiver hold-off; %0d LCD transfers checked, %0d mismatches.",
             xfers_checked, errors);
    if (errors == 0 && xfer_due_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lcdseq_pkg.sv
design/lcdseq_front.sv
design/lcdseq_queue.sv
design/lcdseq_back.sv
design/char_lcd_command_sequencer_top.sv
design/lcdseq_checker.sv
dv/char_lcd_command_sequencer_top_tb.sv
